// ===== src/mprc_pkg.sv =====
// shared types, register indexes and the median edge predictor
// used by mprc_skid and med_predictor_residual_codec_top
package mprc_pkg;

    localparam int unsigned RowWidthBits = 13;
    localparam logic [RowWidthBits-1:0] RowWidthReset = 13'd4096;

    typedef enum logic {
        CFG_ROW_WIDTH   = 1'b0,
        CFG_DECODE_MODE = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic signed [8:0] value;
        logic              is_raw;
    } t_result;

    function automatic logic [7:0] med_predict(
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [7:0] c
    );
        logic [7:0] lo;
        logic [7:0] hi;
        logic [9:0] sum;
        lo  = (a < b) ? a : b;
        hi  = (a < b) ? b : a;
        sum = {2'b00, a} + {2'b00, b} - {2'b00, c};
        if (c >= hi) begin
            med_predict = lo;
        end else if (c < lo) begin
            med_predict = hi;
        end else begin
            med_predict = sum[7:0];
        end
    endfunction

endpackage

// ===== src/mprc_skid.sv =====
// two-entry output stage: output register plus skid register
// depends on mprc_pkg for the result word type
module mprc_skid
    import mprc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_word,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_word
);

    logic    r_out_v;
    logic    r_skd_v;
    t_result r_out;
    t_result r_skd;
    logic    taken;

    assign taken   = r_out_v && i_ready;
    assign o_space = !r_skd_v;
    assign o_valid = r_out_v;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else begin
            if (i_push) begin
                if (!r_out_v || taken) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_skd_v <= 1'b1;
                end
            end else if (taken) begin
                r_out_v <= r_skd_v;
                r_skd_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_v || taken) begin
                r_out <= i_word;
            end else begin
                r_skd <= i_word;
            end
        end else if (taken) begin
            r_out <= r_skd;
        end
    end

endmodule

// ===== src/med_predictor_residual_codec_top.sv =====
// median edge detector residual encoder / decoder for one 8-bit plane
// depends on mprc_pkg and mprc_skid
//
// channel   direction  handshake                  payload
// input     in         i_valid / o_ready          i_sample, i_start_of_frame
// result    out        o_valid / i_ready          o_value, o_is_raw
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one word per clock in and out while the output is not stalled; the line
// store is read ahead at the next column by a registered read, so each word
// is finished in the cycle it is accepted and then held in the output stage.
// synchronous active-low reset; the line store is not cleared.
// input is held off only while both output slots are full.
module med_predictor_residual_codec_top
    import mprc_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [8:0]       i_sample,
    input  logic                    i_start_of_frame,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [8:0]       o_value,
    output logic                    o_is_raw,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_index,
    input  logic [RowWidthBits-1:0] i_cfg_data
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = (CW + 1 > RowWidthBits) ? CW + 1 : RowWidthBits;
    localparam logic [WW-1:0] MaxW = WW'(MAX_WIDTH);

    logic [RowWidthBits-1:0] r_row_width;
    logic                    r_decode;
    logic [CW-1:0]           r_col;
    logic [CW-1:0]           n_col;
    logic                    r_first;
    logic                    n_first;
    logic [7:0]              r_left;
    logic [7:0]              r_ul;
    logic [7:0]              r_upper;
    logic [7:0]              r_line [MAX_WIDTH];

    logic          accept;
    logic          space;
    logic [WW-1:0] width_ext;
    logic [WW-1:0] width_eff;
    logic [CW-1:0] col;
    logic          first;
    logic          raw;
    logic [WW-1:0] col_inc;
    logic          last;
    logic [CW-1:0] rd_addr;
    logic [7:0]    pred;
    logic [7:0]    pixel;
    logic [8:0]    diff;
    t_result       word;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = space;
    assign accept      = i_valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= RowWidthReset;
            r_decode    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ROW_WIDTH:   r_row_width <= i_cfg_data;
                CFG_DECODE_MODE: r_decode    <= i_cfg_data[0];
                default:         r_decode    <= r_decode;
            endcase
        end
    end

    always_comb begin
        width_ext = WW'(r_row_width);
        priority if (width_ext == '0) begin
            width_eff = WW'(1);
        end else if (width_ext > MaxW) begin
            width_eff = MaxW;
        end else begin
            width_eff = width_ext;
        end
    end

    always_comb begin
        col     = i_start_of_frame ? '0 : r_col;
        first   = i_start_of_frame || r_first;
        raw     = first || (col == '0);
        col_inc = WW'(col) + WW'(1);
        last    = col_inc >= width_eff;
        n_col   = last ? '0 : col_inc[CW-1:0];
        n_first = last ? 1'b0 : first;
        rd_addr = accept ? n_col : r_col;
    end

    always_comb begin
        pred = med_predict(r_left, r_upper, r_ul);
        diff = 9'(i_sample[7:0]) - 9'(pred);
        if (raw) begin
            pixel      = i_sample[7:0];
            word.value = $signed({1'b0, i_sample[7:0]});
        end else if (r_decode) begin
            pixel      = i_sample[7:0] + pred;
            word.value = $signed({1'b0, pixel});
        end else begin
            pixel      = i_sample[7:0];
            word.value = $signed(diff);
        end
        word.is_raw = raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
            r_left  <= '0;
            r_ul    <= '0;
        end else if (accept) begin
            r_col   <= n_col;
            r_first <= n_first;
            r_left  <= pixel;
            r_ul    <= r_upper;
        end
    end

    // line store: write current column, read the next one on accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line[col] <= pixel;
        end
        r_upper <= r_line[rd_addr];
    end

    mprc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_word  (word),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  ({o_value, o_is_raw})
    );

endmodule

// ===== bench/tb.sv =====
// self-checking bench for med_predictor_residual_codec_top: queued pixel and residual words,
// a built-in median edge predictor and scoreboard, random stalls on both channels
// depends on mprc_pkg and the codec rtl
module tb;
    import mprc_pkg::*;

    localparam int unsigned LineDepth = 4096;

    typedef struct {
        logic signed [8:0] sample;
        logic              sof;
    } t_word;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic signed [8:0]       i_sample = '0;
    logic                    i_start_of_frame = 1'b0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic signed [8:0]       o_value;
    logic                    o_is_raw;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic                    i_cfg_index = CFG_ROW_WIDTH;
    logic [RowWidthBits-1:0] i_cfg_data = '0;

    t_word       pending_words[$];
    t_result     results_due[$];
    int unsigned err_count = 0;
    int unsigned result_idx = 0;
    bit          calm_tail = 1'b0;
    int unsigned in_gap = 0;
    int unsigned out_gap = 0;

    // predictor copy of the block state
    logic [7:0]              line_mem [LineDepth];
    logic [7:0]              left_px = '0;
    logic [7:0]              upleft_px = '0;
    int unsigned             col_cnt = 0;
    bit                      first_row = 1'b1;
    logic [RowWidthBits-1:0] width_reg = RowWidthReset;
    bit                      decode_reg = 1'b0;

    // stimulus side bookkeeping
    int unsigned gen_eff_width = LineDepth;
    logic [7:0]  gen_last = 8'd128;

    med_predictor_residual_codec_top #(
        .MAX_WIDTH(LineDepth)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .i_start_of_frame(i_start_of_frame),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_value         (o_value),
        .o_is_raw        (o_is_raw),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        foreach (line_mem[k]) line_mem[k] = '0;
    end

    function automatic int unsigned eff_width(input logic [RowWidthBits-1:0] w);
        if (w == 0) return 1;
        if (w > LineDepth) return LineDepth;
        return 32'(w);
    endfunction

    function automatic logic [7:0] edge_median(
        input logic [7:0] w_px,
        input logic [7:0] n_px,
        input logic [7:0] nw_px
    );
        logic [7:0] lo;
        logic [7:0] hi;
        int         grad;
        lo = (w_px < n_px) ? w_px : n_px;
        hi = (w_px < n_px) ? n_px : w_px;
        grad = int'(w_px) + int'(n_px) - int'(nw_px);
        if (nw_px >= hi) return lo;
        if (nw_px < lo) return hi;
        return grad[7:0];
    endfunction

    task automatic predict_word(input logic signed [8:0] s, input logic sof);
        int unsigned w;
        int unsigned col;
        logic [7:0]  up;
        logic [7:0]  pix;
        logic [7:0]  pr;
        logic [8:0]  res;
        bit          raw;
        t_result     r;
        w = eff_width(width_reg);
        if (sof) begin
            col_cnt = 0;
            first_row = 1'b1;
        end
        col = col_cnt % LineDepth;
        up = line_mem[col];
        raw = first_row || col == 0;
        if (raw) begin
            pix = s[7:0];
            res = {1'b0, pix};
        end else begin
            pr = edge_median(left_px, up, upleft_px);
            if (decode_reg) begin
                pix = s[7:0] + pr;
                res = {1'b0, pix};
            end else begin
                pix = s[7:0];
                res = {1'b0, pix} - {1'b0, pr};
            end
        end
        upleft_px = up;
        left_px = pix;
        line_mem[col] = pix;
        if (col + 1 >= w) begin
            col_cnt = 0;
            first_row = 1'b0;
        end else begin
            col_cnt = col + 1;
        end
        r.value = res;
        r.is_raw = raw;
        results_due = {results_due, r};
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        err_count++;
    endtask

    // input driver
    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            in_gap <= 0;
        end else begin
            if (i_valid && o_ready) predict_word(i_sample, i_start_of_frame);
            if (!i_valid || o_ready) begin
                if (in_gap != 0) begin
                    in_gap <= in_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_words.size() != 0 && !calm_tail
                             && $urandom_range(0, 4) == 0) begin
                    in_gap <= $urandom_range(0, 2);
                    i_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    i_valid <= 1'b1;
                    i_sample <= w.sample;
                    i_start_of_frame <= w.sof;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            out_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d: no word expected", result_idx));
                end else begin
                    exp_r = results_due.pop_front();
                    if (o_value !== exp_r.value)
                        report_mismatch($sformatf("result %0d: value %0d expected %0d",
                            result_idx, o_value, exp_r.value));
                    if (o_is_raw !== exp_r.is_raw)
                        report_mismatch($sformatf("result %0d: is_raw %0b expected %0b",
                            result_idx, o_is_raw, exp_r.is_raw));
                end
                result_idx++;
            end
            if (out_gap != 0) begin
                out_gap <= out_gap - 1;
                i_ready <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
                out_gap <= $urandom_range(0, 2);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_valid || results_due.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [RowWidthBits-1:0] data);
        wait_idle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ROW_WIDTH) width_reg = data;
        else decode_reg = data[0];
    endtask

    // a wider row than before must open a new plane so no unwritten entry is read
    task automatic set_mode(input logic [RowWidthBits-1:0] w, input bit dec, output bit grow);
        grow = eff_width(w) > gen_eff_width;
        gen_eff_width = eff_width(w);
        write_reg(CFG_ROW_WIDTH, w);
        write_reg(CFG_DECODE_MODE, {{(RowWidthBits-1){1'b0}}, dec});
    endtask

    task automatic push_word(input int s, input bit sof);
        t_word w;
        w.sample = s[8:0];
        w.sof = sof;
        pending_words = {pending_words, w};
    endtask

    function automatic int rand_sample(input bit dec);
        int v;
        if ($urandom_range(0, 7) == 0) begin
            v = int'($urandom_range(0, 510)) - 255;
        end else if (dec) begin
            if ($urandom_range(0, 3) == 0) v = int'($urandom_range(0, 64)) - 32;
            else v = int'($urandom_range(0, 16)) - 8;
        end else if ($urandom_range(0, 1) == 0) begin
            v = int'($urandom_range(0, 255));
        end else begin
            v = int'(gen_last) + int'($urandom_range(0, 12)) - 6;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
        end
        if (!dec) gen_last = v[7:0];
        return v;
    endfunction

    task automatic run_phase(input logic [RowWidthBits-1:0] w, input bit dec, input int n);
        bit grow;
        set_mode(w, dec, grow);
        for (int i = 0; i < n; i++)
            push_word(rand_sample(dec), (i == 0 && grow) || $urandom_range(0, 39) == 0);
    endtask

    function automatic logic [RowWidthBits-1:0] rand_width();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return RowWidthBits'(1);
            2: return RowWidthBits'($urandom_range(2, 4));
            3: return RowWidthBits'($urandom_range(5, 24));
            4: return RowWidthBits'($urandom_range(25, 200));
            default: return RowWidthBits'($urandom_range(LineDepth + 1, 8191));
        endcase
    endfunction

    initial begin
        bit grow;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // raw words after reset with no start of frame, sample extremes
        push_word(0, 0);
        push_word(255, 0);
        push_word(-255, 0);
        push_word(-1, 0);
        push_word(1, 0);

        // width drops mid-row, then all three predictor branches
        set_mode(13'd3, 1'b0, grow);
        push_word(5, 0);
        push_word(10, 0);
        push_word(200, 0);
        push_word(50, 0);
        push_word(27, 0);
        push_word(30, 0);
        push_word(40, 0);
        push_word(25, 0);
        push_word(-10, 0);
        push_word(255, 0);
        push_word(7, 1);
        push_word(8, 0);
        push_word(9, 0);

        // decode with wrap on rebuild
        set_mode(13'd3, 1'b1, grow);
        push_word(-1, 1);
        push_word(5, 0);
        push_word(-255, 0);
        push_word(0, 0);
        push_word(255, 0);
        push_word(-128, 0);

        // zero width acts as one
        set_mode(13'd0, 1'b0, grow);
        push_word(17, 0);
        push_word(-200, 0);
        push_word(99, 0);

        // oversize width clamps to the line depth
        run_phase(13'd8191, 1'b0, 60);

        for (int p = 0; p < 9; p++)
            run_phase(rand_width(), 1'($urandom_range(0, 1)), 80);

        wait_idle();
        calm_tail = 1'b1;
        run_phase(RowWidthBits'($urandom_range(1, 12)), 1'($urandom_range(0, 1)), 150);

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/mprc_pkg.sv
src/mprc_skid.sv
src/med_predictor_residual_codec_top.sv
bench/tb.sv
